// ===== rtl/core/flock_cohesion_steering_unit_assert.svh =====
// Assertion macros for the flock cohesion steering unit.
// Uses clk_i and rst_ni of the including module; no other dependencies.
`ifndef FLOCK_COHESION_STEERING_UNIT_ASSERT_SVH
`define FLOCK_COHESION_STEERING_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define FCS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define FCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/fcs_pkg.sv =====
// Shared types and constants of the flock cohesion steering unit.
// No dependencies; used by flock_cohesion_steering_unit and its testbench.
package fcs_pkg;

  // Field widths
  localparam int unsigned PosW    = 16;
  localparam int unsigned RadiusW = 15;
  localparam int unsigned MaxAccW = 12;
  localparam int unsigned AccW    = 13;

  // Register indexes and reset values
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_RADIUS  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_ACC = 2'd1;
  localparam logic [RadiusW-1:0] RADIUS_RST  = 15'd2400;
  localparam logic [MaxAccW-1:0] MAX_ACC_RST = 12'd160;

  // Quotient of the scaled square ratio is at most 4*max_acc^2 < 2^26
  localparam int unsigned QuoW      = 2 * MaxAccW + 2;
  localparam int unsigned RootW     = QuoW / 2;
  localparam int unsigned SqrtSteps = QuoW / 2;
  localparam int unsigned SqRemW    = RootW + 2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQX,
    S_SQY,
    S_SQR,
    S_FIN,
    S_NOX,
    S_NOY,
    S_CHK,
    S_LX,
    S_LY,
    S_PX,
    S_PSQ,
    S_DIV,
    S_SQRT,
    S_OUT
  } fcs_state_e;

endpackage

// ===== rtl/core/fcs_mul.sv =====
// Shift-add unsigned multiplier, one multiplier bit per cycle.
// Depends on nothing; instantiated by flock_cohesion_steering_unit.
module fcs_mul #(
  parameter int unsigned AW = 36
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [AW-1:0]   a_i,
  input  logic [AW-1:0]   b_i,
  output logic            busy_o,
  output logic            done_o,
  output logic [2*AW-1:0] prod_o
);

  logic            busy_q, busy_d;
  logic [2*AW-1:0] a_q, a_d;
  logic [AW-1:0]   b_q, b_d;
  logic [2*AW-1:0] p_q, p_d;

  // Load operands, then add the shifted multiplicand per set bit until b runs out
  always_comb begin
    busy_d = busy_q;
    a_d    = a_q;
    b_d    = b_q;
    p_d    = p_q;
    done_o = 1'b0;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      a_d    = {{AW{1'b0}}, a_i};
      b_d    = b_i;
      p_d    = '0;
    end else if (busy_q) begin
      if (b_q == '0) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end else begin
        if (b_q[0]) begin
          p_d = p_q + a_q;
        end
        a_d = a_q << 1;
        b_d = b_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    p_q <= p_d;
  end

  assign busy_o = busy_q;
  assign prod_o = p_q;

endmodule

// ===== rtl/core/flock_cohesion_steering_unit.sv =====
// Channel  | Handshake                | Payload
// cfg      | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
// in       | in_valid_i / in_ready_o  | owner_x/y, other_x/y, present, is_owner, last
// out      | out_valid_o / out_ready_i| found_o, acc_x_o, acc_y_o
//
// One item at a time: an item that is neither a candidate nor last leaves the unit
// idle; a candidate adds three fcs_mul squarings (dx, dy, radius). A last item with
// near neighbours adds two count products; if the direction is nonzero it adds two
// direction squarings, then per component a product, a squaring, a 2*(29+CW)+2 step
// restoring division (74 steps at 64 neighbours) and a 13-step root.
// Reset is asynchronous, active low, and loads the register defaults; a full output
// register stalls only the final result write, and inputs wait meanwhile.
`include "flock_cohesion_steering_unit_assert.svh"

module flock_cohesion_steering_unit #(
  parameter int unsigned MAX_NEIGHBOURS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fcs_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [fcs_pkg::RadiusW-1:0]         cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [fcs_pkg::PosW-1:0]     owner_x_i,
  input  logic signed [fcs_pkg::PosW-1:0]     owner_y_i,
  input  logic signed [fcs_pkg::PosW-1:0]     other_x_i,
  input  logic signed [fcs_pkg::PosW-1:0]     other_y_i,
  input  logic                                present_i,
  input  logic                                is_owner_i,
  input  logic                                last_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                found_o,
  output logic signed [fcs_pkg::AccW-1:0]     acc_x_o,
  output logic signed [fcs_pkg::AccW-1:0]     acc_y_o
);

  localparam int unsigned PW  = fcs_pkg::PosW;
  localparam int unsigned CW  = $clog2(MAX_NEIGHBOURS + 1);
  localparam int unsigned SW  = PW + CW;
  localparam int unsigned DW  = SW + 1;
  localparam int unsigned WA  = DW + fcs_pkg::MaxAccW;
  localparam int unsigned LW  = 2 * DW;
  localparam int unsigned NW  = 2 * WA + 2;
  localparam int unsigned STW = $clog2(NW);
  localparam int unsigned QW  = fcs_pkg::QuoW;
  localparam int unsigned RW  = fcs_pkg::RootW;
  localparam int unsigned SRW = fcs_pkg::SqRemW;
  localparam int unsigned AW  = fcs_pkg::AccW;

  fcs_pkg::fcs_state_e state_q, state_d;

  logic [fcs_pkg::RadiusW-1:0] radius_q;
  logic [fcs_pkg::MaxAccW-1:0] max_acc_q;
  logic [CW-1:0]               cnt_q;
  logic signed [SW-1:0]        sum_x_q, sum_y_q;
  logic                        comp_q;
  logic [STW-1:0]              step_q;

  // item registers
  logic signed [PW-1:0] own_x_q, own_y_q, oth_x_q, oth_y_q;
  logic [PW:0]          mdx_q, mdy_q;
  logic                 last_q;

  // closing datapath
  logic [2*WA-1:0]      d2_q;
  logic signed [DW-1:0] dx_q, dy_q;
  logic [LW-1:0]        len_q;
  logic [WA-1:0]        p_q;
  logic [NW-1:0]        dvd_q;
  logic [LW-1:0]        rem_q;
  logic [QW-1:0]        quo_q;
  logic [SRW-1:0]       sr_q;
  logic [RW-1:0]        root_q;
  logic                 res_found_q;
  logic signed [AW-1:0] res_x_q, res_y_q;

  // output register
  logic                 out_valid_q;
  logic                 found_q;
  logic signed [AW-1:0] acc_x_q, acc_y_q;

  // multiplier
  logic              mul_start, mul_busy, mul_done;
  logic [WA-1:0]     mul_a, mul_b;
  logic [2*WA-1:0]   mul_prod;

  logic              in_xfer, out_load, mul_state, near;
  logic signed [PW:0] it_dx, it_dy;
  logic [DW-1:0]     mag_dx, mag_dy, mag_c;
  logic [PW-1:0]     mag_ox, mag_oy;
  logic [DW-1:0]     no_mag;
  logic signed [DW-1:0] sum_ext, d_next;
  logic              own_neg;
  logic [LW:0]       div_trial;
  logic              div_ge;
  logic [SRW-1:0]    sq_trial, sq_sub;
  logic              sq_ge;
  logic [RW-1:0]     root_nx;
  logic [RW:0]       root_inc;
  logic [AW-1:0]     k_mag;
  logic signed [AW-1:0] k_signed;

  // Item differences and magnitudes
  always_comb begin
    it_dx  = {other_x_i[PW-1], other_x_i} - {owner_x_i[PW-1], owner_x_i};
    it_dy  = {other_y_i[PW-1], other_y_i} - {owner_y_i[PW-1], owner_y_i};
    mag_dx = dx_q[DW-1] ? $unsigned(-dx_q) : $unsigned(dx_q);
    mag_dy = dy_q[DW-1] ? $unsigned(-dy_q) : $unsigned(dy_q);
    mag_c  = comp_q ? mag_dy : mag_dx;
    mag_ox = own_x_q[PW-1] ? $unsigned(-own_x_q) : $unsigned(own_x_q);
    mag_oy = own_y_q[PW-1] ? $unsigned(-own_y_q) : $unsigned(own_y_q);
  end

  // Direction component: sum minus count times owner position
  always_comb begin
    no_mag  = mul_prod[DW-1:0];
    if (state_q == fcs_pkg::S_NOY) begin
      sum_ext = {sum_y_q[SW-1], sum_y_q};
      own_neg = own_y_q[PW-1];
    end else begin
      sum_ext = {sum_x_q[SW-1], sum_x_q};
      own_neg = own_x_q[PW-1];
    end
    d_next = own_neg ? sum_ext + $signed(no_mag) : sum_ext - $signed(no_mag);
  end

  // Restoring division step and root step
  always_comb begin
    div_trial = {rem_q, dvd_q[NW-1]};
    div_ge    = div_trial >= {1'b0, len_q};
    sq_trial  = {sr_q[SRW-3:0], quo_q[QW-1:QW-2]};
    sq_sub    = {root_q, 2'b01};
    sq_ge     = sq_trial >= sq_sub;
    root_nx   = {root_q[RW-2:0], sq_ge};
    root_inc  = {1'b0, root_nx} + {{RW{1'b0}}, 1'b1};
    k_mag     = root_inc[RW:1];
    k_signed  = (comp_q ? dy_q[DW-1] : dx_q[DW-1]) ? -$signed(k_mag) : $signed(k_mag);
  end

  assign near = (d2_q < mul_prod) && (cnt_q < CW'(MAX_NEIGHBOURS));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fcs_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (present_i && !is_owner_i) state_d = fcs_pkg::S_SQX;
          else if (last_i)              state_d = fcs_pkg::S_FIN;
        end
      end
      fcs_pkg::S_SQX: if (mul_done) state_d = fcs_pkg::S_SQY;
      fcs_pkg::S_SQY: if (mul_done) state_d = fcs_pkg::S_SQR;
      fcs_pkg::S_SQR: begin
        if (mul_done) state_d = last_q ? fcs_pkg::S_FIN : fcs_pkg::S_IDLE;
      end
      fcs_pkg::S_FIN: state_d = (cnt_q == '0) ? fcs_pkg::S_OUT : fcs_pkg::S_NOX;
      fcs_pkg::S_NOX: if (mul_done) state_d = fcs_pkg::S_NOY;
      fcs_pkg::S_NOY: if (mul_done) state_d = fcs_pkg::S_CHK;
      fcs_pkg::S_CHK: begin
        state_d = (dx_q == '0 && dy_q == '0) ? fcs_pkg::S_OUT : fcs_pkg::S_LX;
      end
      fcs_pkg::S_LX:  if (mul_done) state_d = fcs_pkg::S_LY;
      fcs_pkg::S_LY:  if (mul_done) state_d = fcs_pkg::S_PX;
      fcs_pkg::S_PX:  if (mul_done) state_d = fcs_pkg::S_PSQ;
      fcs_pkg::S_PSQ: if (mul_done) state_d = fcs_pkg::S_DIV;
      fcs_pkg::S_DIV: if (step_q == STW'(NW - 1)) state_d = fcs_pkg::S_SQRT;
      fcs_pkg::S_SQRT: begin
        if (step_q == STW'(fcs_pkg::SqrtSteps - 1)) begin
          state_d = comp_q ? fcs_pkg::S_OUT : fcs_pkg::S_PX;
        end
      end
      fcs_pkg::S_OUT: if (out_load) state_d = fcs_pkg::S_IDLE;
      default:        state_d = fcs_pkg::S_IDLE;
    endcase
  end

  // Handshake and multiplier operand selection
  always_comb begin
    in_ready_o = (state_q == fcs_pkg::S_IDLE);
    in_xfer    = in_valid_i && in_ready_o;
    out_load   = (state_q == fcs_pkg::S_OUT) && (!out_valid_q || out_ready_i);
    mul_state  = 1'b1;
    mul_a      = '0;
    mul_b      = '0;
    case (state_q)
      fcs_pkg::S_SQX: begin mul_a = WA'(mdx_q);    mul_b = WA'(mdx_q);     end
      fcs_pkg::S_SQY: begin mul_a = WA'(mdy_q);    mul_b = WA'(mdy_q);     end
      fcs_pkg::S_SQR: begin mul_a = WA'(radius_q); mul_b = WA'(radius_q);  end
      fcs_pkg::S_NOX: begin mul_a = WA'(mag_ox);   mul_b = WA'(cnt_q);     end
      fcs_pkg::S_NOY: begin mul_a = WA'(mag_oy);   mul_b = WA'(cnt_q);     end
      fcs_pkg::S_LX:  begin mul_a = WA'(mag_dx);   mul_b = WA'(mag_dx);    end
      fcs_pkg::S_LY:  begin mul_a = WA'(mag_dy);   mul_b = WA'(mag_dy);    end
      fcs_pkg::S_PX:  begin mul_a = WA'(mag_c);    mul_b = WA'(max_acc_q); end
      fcs_pkg::S_PSQ: begin mul_a = p_q;           mul_b = p_q;            end
      default:        mul_state = 1'b0;
    endcase
    mul_start = mul_state && !mul_busy;
  end

  fcs_mul #(
    .AW(WA)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .busy_o (mul_busy),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  // Control state: registers, accumulators, counters, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fcs_pkg::S_IDLE;
      radius_q    <= fcs_pkg::RADIUS_RST;
      max_acc_q   <= fcs_pkg::MAX_ACC_RST;
      cnt_q       <= '0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      comp_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == fcs_pkg::REG_RADIUS)  radius_q  <= cfg_wdata_i;
        if (cfg_idx_i == fcs_pkg::REG_MAX_ACC) max_acc_q <= cfg_wdata_i[fcs_pkg::MaxAccW-1:0];
      end
      // accumulate a near neighbour
      if (state_q == fcs_pkg::S_SQR && mul_done && near) begin
        sum_x_q <= sum_x_q + SW'(oth_x_q);
        sum_y_q <= sum_y_q + SW'(oth_y_q);
        cnt_q   <= cnt_q + CW'(1);
      end
      if (state_q == fcs_pkg::S_FIN) comp_q <= 1'b0;
      if (state_q == fcs_pkg::S_SQRT && step_q == STW'(fcs_pkg::SqrtSteps - 1)) begin
        comp_q <= 1'b1;
      end
      // step counter for division and root
      if (state_q == fcs_pkg::S_PSQ ||
          (state_q == fcs_pkg::S_DIV && step_q == STW'(NW - 1))) begin
        step_q <= '0;
      end else if (state_q == fcs_pkg::S_DIV || state_q == fcs_pkg::S_SQRT) begin
        step_q <= step_q + STW'(1);
      end
      // drop the run and hand the result over
      if (out_load) begin
        sum_x_q <= '0;
        sum_y_q <= '0;
        cnt_q   <= '0;
      end
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      own_x_q <= owner_x_i;
      own_y_q <= owner_y_i;
      oth_x_q <= other_x_i;
      oth_y_q <= other_y_i;
      mdx_q   <= it_dx[PW] ? $unsigned(-it_dx) : $unsigned(it_dx);
      mdy_q   <= it_dy[PW] ? $unsigned(-it_dy) : $unsigned(it_dy);
      last_q  <= last_i;
    end
    case (state_q)
      fcs_pkg::S_SQX: if (mul_done) d2_q <= mul_prod;
      fcs_pkg::S_SQY: if (mul_done) d2_q <= d2_q + mul_prod;
      fcs_pkg::S_FIN: begin
        res_found_q <= 1'b0;
        res_x_q     <= '0;
        res_y_q     <= '0;
      end
      fcs_pkg::S_NOX: if (mul_done) dx_q <= d_next;
      fcs_pkg::S_NOY: if (mul_done) dy_q <= d_next;
      fcs_pkg::S_CHK: res_found_q <= 1'b1;
      fcs_pkg::S_LX:  if (mul_done) len_q <= mul_prod[LW-1:0];
      fcs_pkg::S_LY:  if (mul_done) len_q <= len_q + mul_prod[LW-1:0];
      fcs_pkg::S_PX:  if (mul_done) p_q <= mul_prod[WA-1:0];
      fcs_pkg::S_PSQ: begin
        if (mul_done) begin
          dvd_q <= {mul_prod, 2'b00};
          rem_q <= '0;
        end
      end
      fcs_pkg::S_DIV: begin
        dvd_q <= dvd_q << 1;
        rem_q <= div_ge ? LW'(div_trial - {1'b0, len_q}) : div_trial[LW-1:0];
        quo_q <= {quo_q[QW-2:0], div_ge};
        sr_q   <= '0;
        root_q <= '0;
      end
      fcs_pkg::S_SQRT: begin
        sr_q   <= sq_ge ? sq_trial - sq_sub : sq_trial;
        root_q <= root_nx;
        quo_q  <= quo_q << 2;
        if (step_q == STW'(fcs_pkg::SqrtSteps - 1)) begin
          if (comp_q) res_y_q <= k_signed;
          else        res_x_q <= k_signed;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      found_q <= res_found_q;
      acc_x_q <= res_x_q;
      acc_y_q <= res_y_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign acc_x_o     = acc_x_q;
  assign acc_y_o     = acc_y_q;

  // Checks
  `FCS_ASSERT(a_cnt_bound, 1'b1, cnt_q <= CW'(MAX_NEIGHBOURS), "near count above limit")
  `FCS_ASSERT(a_idle_mul, in_ready_o, !mul_busy, "multiplier busy while idle")
  `FCS_ASSERT(a_nf_zero, out_valid_o && !found_o, acc_x_o == '0 && acc_y_o == '0, "acc without neighbours")
  `FCS_ASSERT_NEXT(a_run_clear, out_load, cnt_q == '0 && sum_x_q == '0 && sum_y_q == '0, "run not cleared")

endmodule

// ===== test/flock_cohesion_steering_unit_tb.sv =====
// Self-checking testbench for flock_cohesion_steering_unit: streams neighbour runs,
// predicts each cohesion result in a scoreboard class and compares field by field.
// Depends on fcs_pkg and the flock_cohesion_steering_unit RTL.
module flock_cohesion_steering_unit_tb;

  localparam int unsigned PosW    = fcs_pkg::PosW;
  localparam int unsigned AccW    = fcs_pkg::AccW;
  localparam int unsigned RadiusW = fcs_pkg::RadiusW;
  localparam int unsigned MaxAccW = fcs_pkg::MaxAccW;
  localparam int unsigned CfgIdxW = fcs_pkg::CfgIdxW;

  // Index beyond the register file; writes to it are ignored
  localparam logic [CfgIdxW-1:0] RegNone = 2'd2;

  typedef struct {
    logic signed [PosW-1:0] owner_x;
    logic signed [PosW-1:0] owner_y;
    logic signed [PosW-1:0] other_x;
    logic signed [PosW-1:0] other_y;
    logic present;
    logic is_owner;
    logic last;
  } slot_t;

  typedef struct {
    logic found;
    logic signed [AccW-1:0] acc_x;
    logic signed [AccW-1:0] acc_y;
  } steer_t;

  localparam int unsigned MaxNear = 64;

  // Cohesion predictor and store of pending steering results
  class cohesion_scoreboard;
    steer_t pending_q[$];
    logic [RadiusW-1:0] radius = fcs_pkg::RADIUS_RST;
    logic [MaxAccW-1:0] max_acc = fcs_pkg::MAX_ACC_RST;
    longint sum_x, sum_y;
    int unsigned near_cnt;
    int unsigned errors;

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [RadiusW-1:0] val);
      if (idx == fcs_pkg::REG_RADIUS) radius = val;
      else if (idx == fcs_pkg::REG_MAX_ACC) max_acc = val[MaxAccW-1:0];
    endfunction

    // Rounded max_acc * comp / sqrt(len2), found by bisection on the root
    function longint scaled_comp(longint comp, longint unsigned len2);
      longint unsigned mag, q2, lo, hi, k, odd;
      bit [127:0] lhs, rhs;
      mag = comp < 0 ? -comp : comp;
      q2 = 2 * longint'(max_acc) * mag;
      lo = 0;
      hi = max_acc;
      while (lo < hi) begin
        k = (lo + hi + 1) / 2;
        odd = 2 * k - 1;
        lhs = 128'(odd * odd) * 128'(len2);
        rhs = 128'(q2) * 128'(q2);
        if (lhs <= rhs) lo = k;
        else hi = k - 1;
      end
      return comp < 0 ? -longint'(lo) : longint'(lo);
    endfunction

    function void note_slot(slot_t s);
      longint dx, dy, n;
      longint unsigned d2, len2;
      steer_t r;
      if (s.present && !s.is_owner) begin
        dx = longint'(s.other_x) - longint'(s.owner_x);
        dy = longint'(s.other_y) - longint'(s.owner_y);
        d2 = dx * dx + dy * dy;
        if (d2 < longint'(radius) * longint'(radius) && near_cnt < MaxNear) begin
          sum_x += s.other_x;
          sum_y += s.other_y;
          near_cnt++;
        end
      end
      if (!s.last) return;
      r = '{1'b0, '0, '0};
      if (near_cnt != 0) begin
        n = near_cnt;
        dx = sum_x - n * longint'(s.owner_x);
        dy = sum_y - n * longint'(s.owner_y);
        r.found = 1'b1;
        if (dx != 0 || dy != 0) begin
          len2 = dx * dx + dy * dy;
          r.acc_x = AccW'(scaled_comp(dx, len2));
          r.acc_y = AccW'(scaled_comp(dy, len2));
        end
      end
      pending_q.push_back(r);
      sum_x = 0;
      sum_y = 0;
      near_cnt = 0;
    endfunction

    function void check_result(steer_t got);
      steer_t exp_r;
      if (pending_q.size() == 0) begin
        $error("unexpected result found=%0d acc_x=%0d acc_y=%0d",
               got.found, got.acc_x, got.acc_y);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.found !== exp_r.found) begin
        $error("found: expected %0d actual %0d", exp_r.found, got.found);
        errors++;
      end
      if (got.acc_x !== exp_r.acc_x) begin
        $error("acc_x: expected %0d actual %0d", exp_r.acc_x, got.acc_x);
        errors++;
      end
      if (got.acc_y !== exp_r.acc_y) begin
        $error("acc_y: expected %0d actual %0d", exp_r.acc_y, got.acc_y);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [RadiusW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [PosW-1:0] owner_x_i = '0, owner_y_i = '0, other_x_i = '0, other_y_i = '0;
  logic present_i = 1'b0, is_owner_i = 1'b0, last_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic found_o;
  logic signed [AccW-1:0] acc_x_o, acc_y_o;

  int unsigned send_idle_pct = 12;
  int unsigned recv_idle_pct = 79;
  cohesion_scoreboard sb = new();

  flock_cohesion_steering_unit uut (.*);

  always #5 clk_i = ~clk_i;

  // Sample output transfers and throttle the receiver
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result('{found_o, acc_x_o, acc_y_o});
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Drive one slot and hold it until the transfer
  task automatic send_slot(slot_t s);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    owner_x_i  <= s.owner_x;
    owner_y_i  <= s.owner_y;
    other_x_i  <= s.other_x;
    other_y_i  <= s.other_y;
    present_i  <= s.present;
    is_owner_i <= s.is_owner;
    last_i     <= s.last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_slot(s);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (1200) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [RadiusW-1:0] val);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  function automatic slot_t mk(int ox, int oy, int nx, int ny, bit p, bit own, bit lst);
    slot_t s;
    s = '{PosW'(ox), PosW'(oy), PosW'(nx), PosW'(ny), p, own, lst};
    return s;
  endfunction

  // Random run around one owner; most neighbours land near it
  task automatic send_run(int unsigned len);
    logic signed [PosW-1:0] ox, oy;
    int span;
    slot_t s;
    ox = PosW'($urandom);
    oy = PosW'($urandom);
    span = int'(sb.radius) + 16;
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(99) < 70)
        s = mk(ox, oy, int'(ox) + int'($urandom_range(2 * span)) - span,
               int'(oy) + int'($urandom_range(2 * span)) - span, 1'b1, 1'b0, 1'b0);
      else
        s = mk(ox, oy, int'($urandom), int'($urandom), 1'b1, 1'b0, 1'b0);
      if ($urandom_range(99) < 10) s.present = 1'b0;
      if ($urandom_range(99) < 10) s.is_owner = 1'b1;
      if ($urandom_range(99) < 3) begin
        s.owner_x = PosW'($urandom);
        s.owner_y = PosW'($urandom);
      end
      s.last = (i == len - 1) || ($urandom_range(99) < 2);
      send_slot(s);
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned len;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty run, single near, owner slot, coincident, extremes, radius edge
    send_slot(mk(0, 0, 5, 5, 1'b0, 1'b0, 1'b1));
    send_slot(mk(0, 0, 160, 0, 1'b1, 1'b0, 1'b1));
    send_slot(mk(0, 0, -160, -160, 1'b1, 1'b0, 1'b1));
    send_slot(mk(100, 100, 100, 100, 1'b1, 1'b1, 1'b0));
    send_slot(mk(100, 100, 150, 90, 1'b1, 1'b0, 1'b1));
    send_slot(mk(300, -300, 300, -300, 1'b1, 1'b0, 1'b1));
    send_slot(mk(-32768, -32768, 32767, 32767, 1'b1, 1'b0, 1'b1));
    send_slot(mk(32767, 32767, 32767, 32767 - 2399, 1'b1, 1'b0, 1'b0));
    send_slot(mk(32767, 32767, 32767 - 2400, 32767, 1'b1, 1'b0, 1'b1));
    send_slot(mk(-32768, 32767, -32768 + 1000, 32767 - 1000, 1'b1, 1'b0, 1'b0));
    send_slot(mk(-32768, 32767, -32768 - 50, 32767, 1'b0, 1'b0, 1'b0));
    send_slot(mk(-32000, 32000, -32000 + 500, 32000, 1'b1, 1'b0, 1'b1));
    send_slot(mk(0, 0, 10, 0, 1'b1, 1'b0, 1'b0));
    send_slot(mk(0, 0, -10, 0, 1'b1, 1'b0, 1'b0));
    send_slot(mk(0, 0, 20, 20, 1'b1, 1'b1, 1'b1));
    send_slot(mk(1, -1, 7, -9, 1'b1, 1'b0, 1'b1));

    // Overflowing run: more near neighbours than the counter admits
    for (int i = 0; i < 70; i++)
      send_slot(mk(0, 0, (i < 64) ? 16 : -2000, 0, 1'b1, 1'b0, i == 69));

    // Random phases across register settings and idling modes
    sent = 0;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(fcs_pkg::REG_RADIUS, 15'd2400);
          write_reg(fcs_pkg::REG_MAX_ACC, 15'h7FFF);
        end
        1: begin
          write_reg(fcs_pkg::REG_RADIUS, 15'd32767);
          write_reg(fcs_pkg::REG_MAX_ACC, 15'd1);
        end
        2: begin
          write_reg(fcs_pkg::REG_RADIUS, 15'd0);
          write_reg(fcs_pkg::REG_MAX_ACC, 15'd0);
        end
        3: begin
          write_reg(fcs_pkg::REG_RADIUS, 15'd1);
          write_reg(fcs_pkg::REG_MAX_ACC, 15'd4095);
        end
        default: begin
          write_reg(fcs_pkg::REG_RADIUS, RadiusW'($urandom_range(32767)));
          write_reg(fcs_pkg::REG_MAX_ACC, RadiusW'($urandom));
          write_reg(RegNone, RadiusW'($urandom));
        end
      endcase
      if (phase == 2) begin
        send_idle_pct = 79;
        recv_idle_pct = 12;
      end else if (phase == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      while (sent < (phase + 1) * 310) begin
        len = ($urandom_range(99) < 3) ? $urandom_range(60, 80) : $urandom_range(1, 10);
        send_run(len);
        sent += len;
        if (phase == 3 && $urandom_range(99) < 5) drain();
      end
    end

    drain();
    if (sb.errors == 0)
      $display("flock_cohesion_steering_unit test passed");
    else
      $display("flock_cohesion_steering_unit test failed");
    $finish;
  end

  // Watchdog
  initial begin
    #40000000;
    $display("flock_cohesion_steering_unit test failed");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/fcs_pkg.sv
rtl/core/fcs_mul.sv
rtl/core/flock_cohesion_steering_unit.sv
test/flock_cohesion_steering_unit_tb.sv
